// ----- hw/rtl/lngs_pkg.sv -----
// shared types, constants and helpers for the line number gutter stream
`timescale 1ns / 1ps
`default_nettype none

package lngs_pkg;

  // configuration register indexes
  localparam logic REG_FIRST_LINE = 1'b0;
  localparam logic REG_LINE_LIMIT = 1'b1;

  // field widths and limits
  localparam int unsigned CNT_W = 20;
  localparam logic [CNT_W-1:0] FIELD_MAX = 20'd999999;

  // characters
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [3:0] BCD_NINE   = 4'd9;

  // command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one command for the back end, gutter digits travel beside it
  typedef struct packed {
    logic             is_end;   // end of text: optional newline then done
    logic             end_nl;   // close an open selected line
    logic             gutter;   // emit gutter and tab before the text byte
    logic [7:0]       data;     // text byte
    logic [CNT_W-1:0] total;    // line count at the end
    logic [CNT_W-1:0] emitted;  // emitted line count at the end
    logic             ovf;      // line number saturated
  } lngs_cmd_t;

  // largest line number that fits the gutter, capped at the field maximum
  function automatic logic [CNT_W-1:0] number_limit(input int digits);
    longint lim;
    lim = 1;
    for (int i = 0; i < digits; i++) begin
      if (lim <= longint'(FIELD_MAX)) lim = lim * 10;
    end
    lim = lim - 1;
    if (lim > longint'(FIELD_MAX)) lim = longint'(FIELD_MAX);
    return lim[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lngs_front.sv -----
// front end: accepts text bytes, tracks line state and issues commands
`timescale 1ns / 1ps
`default_nettype none

module lngs_front import lngs_pkg::*; #(
  parameter int GUTTER_DIGITS = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [7:0]                data_byte_i,
  input  logic [CNT_W-1:0]          first_line_i,
  input  logic [CNT_W-1:0]          line_limit_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output lngs_cmd_t                 cmd_o,
  output logic [4*GUTTER_DIGITS-1:0] digits_o
);

  localparam int unsigned DIG_W = 4 * GUTTER_DIGITS;
  localparam logic [CNT_W-1:0] NUM_LIMIT = number_limit(GUTTER_DIGITS);

  logic [CNT_W-1:0] line_count_q, line_count_d;
  logic [DIG_W-1:0] digits_q, digits_d, digits_inc;
  logic [CNT_W-1:0] emitted_q, emitted_d;
  logic             mid_q, mid_d;
  logic             sel_q, sel_d;
  logic             ovf_q, ovf_d;
  logic             accept, is_end, carry, sel;
  logic [CNT_W-1:0] start;
  logic [3:0]       dig;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign is_end     = action_i | (data_byte_i == CHAR_NUL);
  assign start      = (first_line_i == '0) ? CNT_W'(1) : first_line_i;

  // bcd increment of the line number, ripple over the digits
  always_comb begin
    carry      = 1'b1;
    digits_inc = digits_q;
    for (int i = 0; i < GUTTER_DIGITS; i++) begin
      dig = digits_q[4*i +: 4];
      if (carry) begin
        if (dig == BCD_NINE) begin
          digits_inc[4*i +: 4] = 4'd0;
        end else begin
          digits_inc[4*i +: 4] = dig + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  // line state update and command build
  always_comb begin
    line_count_d = line_count_q;
    digits_d     = digits_q;
    emitted_d    = emitted_q;
    mid_d        = mid_q;
    sel_d        = sel_q;
    ovf_d        = ovf_q;
    push_o       = 1'b0;
    cmd_o        = '0;
    sel          = sel_q;
    if (accept) begin
      if (is_end) begin
        push_o       = 1'b1;
        cmd_o.is_end = 1'b1;
        cmd_o.end_nl = mid_q & sel_q;
        cmd_o.total   = line_count_q;
        cmd_o.emitted = emitted_q;
        cmd_o.ovf     = ovf_q;
        line_count_d = '0;
        digits_d     = '0;
        emitted_d    = '0;
        mid_d        = 1'b0;
        sel_d        = 1'b0;
        ovf_d        = 1'b0;
      end else begin
        if (!mid_q) begin
          if (line_count_q < NUM_LIMIT) begin
            line_count_d = line_count_q + CNT_W'(1);
            digits_d     = digits_inc;
          end else begin
            ovf_d = 1'b1;
          end
          sel   = (line_count_d >= start) &&
                  ((line_limit_i == '0) || (emitted_q < line_limit_i));
          sel_d = sel;
          mid_d = 1'b1;
          if (sel) begin
            cmd_o.gutter = 1'b1;
            if (emitted_q < FIELD_MAX) emitted_d = emitted_q + CNT_W'(1);
          end
        end
        if (data_byte_i == CHAR_NL) mid_d = 1'b0;
        push_o     = sel;
        cmd_o.data = data_byte_i;
      end
    end
  end

  assign digits_o = digits_d;

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
      digits_q     <= '0;
      emitted_q    <= '0;
      mid_q        <= 1'b0;
      sel_q        <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      line_count_q <= line_count_d;
      digits_q     <= digits_d;
      emitted_q    <= emitted_d;
      mid_q        <= mid_d;
      sel_q        <= sel_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lngs_queue.sv -----
// short command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module lngs_queue import lngs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0]  mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + QCNT_W'(1);
      else if (pop_i && !push_i) count_q <= count_q - QCNT_W'(1);
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ----- hw/rtl/lngs_back.sv -----
// back end: expands commands into gutter, text and done results
`timescale 1ns / 1ps
`default_nettype none

module lngs_back import lngs_pkg::*; #(
  parameter int GUTTER_DIGITS = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  lngs_cmd_t                  head_cmd_i,
  input  logic [4*GUTTER_DIGITS-1:0] head_digits_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       byte_valid_o,
  output logic                       run_last_o,
  output logic                       text_done_o,
  output logic [CNT_W-1:0]           total_lines_o,
  output logic [CNT_W-1:0]           emitted_lines_o,
  output logic                       overflow_o
);

  localparam int unsigned STEP_W = $clog2(GUTTER_DIGITS + 2);
  localparam logic [STEP_W-1:0] TAB_STEP = STEP_W'(GUTTER_DIGITS);
  localparam logic [STEP_W-1:0] UNIT_STEP = STEP_W'(GUTTER_DIGITS - 1);

  logic [STEP_W-1:0] step_q;
  logic              lead_q;
  logic              out_valid_q;
  logic              load, fire, last, nz_digit;
  logic [3:0]        dig;
  logic [7:0]        res_byte;
  logic              res_bvalid, res_done;

  // pick the digit for this step, most significant first
  always_comb begin
    dig = 4'd0;
    for (int i = 0; i < GUTTER_DIGITS; i++) begin
      if (step_q == STEP_W'(GUTTER_DIGITS - 1 - i)) dig = head_digits_i[4*i +: 4];
    end
  end

  // result for the current step
  always_comb begin
    res_byte   = '0;
    res_bvalid = 1'b1;
    res_done   = 1'b0;
    last       = 1'b0;
    nz_digit   = 1'b0;
    if (head_cmd_i.is_end) begin
      if (head_cmd_i.end_nl && step_q == '0) begin
        res_byte = CHAR_NL;
      end else begin
        res_bvalid = 1'b0;
        res_done   = 1'b1;
        last       = 1'b1;
      end
    end else if (head_cmd_i.gutter && step_q < TAB_STEP) begin
      nz_digit = (dig != 4'd0);
      if (lead_q && !nz_digit && step_q != UNIT_STEP) res_byte = CHAR_SPACE;
      else                                          res_byte = CHAR_ZERO + {4'd0, dig};
    end else if (head_cmd_i.gutter && step_q == TAB_STEP) begin
      res_byte = CHAR_TAB;
    end else begin
      res_byte = head_cmd_i.data;
      last     = 1'b1;
    end
  end

  assign load  = ~out_valid_q | ~out_stall_i;
  assign fire  = head_valid_i & load;
  assign pop_o = fire & last;

  // step sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      lead_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= fire | (out_valid_q & out_stall_i);
      if (fire) begin
        if (last) begin
          step_q <= '0;
          lead_q <= 1'b1;
        end else begin
          step_q <= step_q + STEP_W'(1);
          if (nz_digit) lead_q <= 1'b0;
        end
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_o      <= res_byte;
      byte_valid_o    <= res_bvalid;
      run_last_o      <= last;
      text_done_o     <= res_done;
      total_lines_o   <= res_done ? head_cmd_i.total   : '0;
      emitted_lines_o <= res_done ? head_cmd_i.emitted : '0;
      overflow_o      <= res_done & head_cmd_i.ovf;
    end
  end

  assign out_valid_o = out_valid_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_W'(GUTTER_DIGITS + 1))
    else $error("step counter out of range");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_done_o) |-> (run_last_o && !byte_valid_o))
    else $error("done result not marked last");

  a_pop_resets_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (step_q == '0 && lead_q))
    else $error("sequencer not rewound after command");

endmodule

`default_nettype wire

// ----- hw/rtl/line_number_gutter_stream_core.sv -----
// top level: line numbering gutter stream with configuration registers
//
// Usage: text bytes enter on the input channel (in_valid_i / in_stall_o),
// one per transfer, closed by an end item (action_i high or a zero byte).
// Formatted characters and the final done result leave on the output
// channel (out_valid_o / out_stall_i), one result per transfer.
// first_line and line_limit are to be written over the cfg channel only while
// idle, which the block does not enforce; cfg_ready_o is always high.
// The command queue, written by the front end, and then the output register,
// loaded by the back end, lie between an item's transfer and its first result.
// Throughput: one item per cycle while the queue is not full; an item that
// opens a selected line occupies the back end for GUTTER_DIGITS digits, a
// tab and the byte; an end item closing an open selected line yields a
// newline and the done result. Items of unselected lines yield nothing.
// Reset clears all line state, the queue and the output valid flag, and
// sets first_line to 1 and line_limit to 0.
// While the receiver stalls, the output holds; the two-entry command queue
// fills and then the input channel stalls.
`timescale 1ns / 1ps
`default_nettype none

module line_number_gutter_stream_core import lngs_pkg::*; #(
  parameter int GUTTER_DIGITS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  logic [7:0]       data_byte_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             run_last_o,
  output logic             text_done_o,
  output logic [CNT_W-1:0] total_lines_o,
  output logic [CNT_W-1:0] emitted_lines_o,
  output logic             overflow_o
);

  localparam int unsigned DIG_W = 4 * GUTTER_DIGITS;
  localparam int unsigned Q_W   = $bits(lngs_cmd_t) + DIG_W;

  logic [CNT_W-1:0] first_line_q, line_limit_q;
  logic             push, pop, q_full, q_empty;
  lngs_cmd_t        push_cmd, head_cmd;
  logic [DIG_W-1:0] push_digits, head_digits;
  logic [Q_W-1:0]   q_wdata, q_rdata;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_line_q <= CNT_W'(1);
      line_limit_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FIRST_LINE: first_line_q <= cfg_data_i;
        REG_LINE_LIMIT: line_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lngs_front #(
    .GUTTER_DIGITS(GUTTER_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .first_line_i (first_line_q),
    .line_limit_i (line_limit_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .digits_o     (push_digits)
  );

  assign q_wdata = {push_cmd, push_digits};
  assign {head_cmd, head_digits} = q_rdata;

  lngs_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  lngs_back #(
    .GUTTER_DIGITS(GUTTER_DIGITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (~q_empty),
    .head_cmd_i      (head_cmd),
    .head_digits_i   (head_digits),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .run_last_o      (run_last_o),
    .text_done_o     (text_done_o),
    .total_lines_o   (total_lines_o),
    .emitted_lines_o (emitted_lines_o),
    .overflow_o      (overflow_o)
  );

endmodule

`default_nettype wire
